// ----- hdl/mchw_pkg.sv -----
// Shared types and constants of the multi-channel heartbeat watchdog.
package mchw_pkg;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_HEARTBEAT = 3'd1,
        CMD_RECOVER   = 3'd2,
        CMD_START     = 3'd3,
        CMD_STOP      = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        REG_TIMEOUT = 2'd0,
        REG_GRACE   = 2'd1,
        REG_PERIOD  = 2'd2,
        REG_COUNT   = 2'd3
    } reg_idx_t;

    localparam int MS_BITS     = 16;
    localparam int CH_BITS     = 3;
    localparam int COUNT_BITS  = 4;
    localparam int EVENT_LIMIT = 8;

    localparam logic [MS_BITS-1:0]    TIMEOUT_RESET = 16'd500;
    localparam logic [MS_BITS-1:0]    GRACE_RESET   = 16'd8000;
    localparam logic [MS_BITS-1:0]    PERIOD_RESET  = 16'd50;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET   = 4'd3;

    typedef struct packed {
        logic                  tick;
        logic                  restart;
        logic                  recover;
        logic                  heartbeat;
        logic [CH_BITS-1:0]    channel;
        logic [COUNT_BITS-1:0] mon;
        logic                  pend;
        logic                  step;
        logic                  emit;
    } cell_ctrl_t;

endpackage

// ----- hdl/multi_channel_heartbeat_watchdog.sv -----
// Top level of the multi-channel heartbeat watchdog with its register port.
//
// The s_ channel takes one command beat at a time: tick (one millisecond),
// heartbeat on a channel, recovery, start and stop. Every beat is absorbed as
// it is taken, and s_tready stays high unless a check has events to report.
// While running, a check starts on the tick at which the ticks since the last
// check reach the period register, and it passes a token down the row of
// channel cells, one cell per cycle. Each monitored channel that has just gone
// stale gives one m_ beat carrying its channel, its age and the threshold in
// force; m_tlast marks the final beat of the check. The beat of channel k is
// registered in the output register once the token has reached cell k. A
// check holds s_tready low until the token has passed the last stale channel
// and that channel's event is registered, and longer while m_tready is low
// while an event waits. The output register holds one event, so a new
// command is taken while that event waits. When the receiver stalls, the
// token stops on the cell whose event cannot be handed over. Reset stops the
// block, clears all ages and stale flags and loads the default register
// values. Registers are written through the APB-style port; the user must
// write them only while the block is idle, which the block does not enforce.
module multi_channel_heartbeat_watchdog
    import mchw_pkg::*;
#(
    parameter int CHANNELS = 8,
    parameter int AGE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // command[2:0], channel[5:3], zero[7:6]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // stale_channel[2:0], elapsed[18:3],
                                   // threshold_ms[34:19], zero[39:35]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int MON_MAX = (CHANNELS < EVENT_LIMIT) ? CHANNELS : EVENT_LIMIT;
    localparam int CMP_W   = (AGE_BITS > MS_BITS) ? AGE_BITS : MS_BITS;
    localparam logic [MS_BITS-1:0] MS_MAX = {MS_BITS{1'b1}};

    logic [MS_BITS-1:0]    timeout_reg, grace_reg, period_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [MS_BITS-1:0]    act_reg, act_next;
    logic [MS_BITS-1:0]    div_reg, div_next;
    logic                  running_reg, running_next;

    logic                  out_valid_reg;
    logic [CH_BITS-1:0]    out_ch_reg;
    logic [MS_BITS-1:0]    out_el_reg;
    logic [MS_BITS-1:0]    out_thr_reg;
    logic                  out_last_reg;

    logic                  cfg_wr;
    reg_idx_t              cfg_idx;
    logic                  s_acc;
    cmd_t                  cmd;
    logic [CH_BITS-1:0]    ch;
    logic [COUNT_BITS-1:0] mon;
    logic [MS_BITS-1:0]    thr;
    logic [MS_BITS-1:0]    div_inc;
    logic                  launch;
    logic                  pend, step, emit, tok_hit, later, out_free;
    cell_ctrl_t            ctrl;

    logic [CHANNELS:0]     tok_chain;
    logic [CHANNELS:0]     seen_chain;
    logic [CHANNELS-1:0]   hit_vec;
    logic [CHANNELS-1:0]   tok_vec;
    logic [AGE_BITS-1:0]   age_sel [CHANNELS];
    logic [AGE_BITS-1:0]   tok_age;
    logic [CMP_W-1:0]      tok_age_ext;
    logic [CH_BITS-1:0]    tok_idx;
    logic [MS_BITS-1:0]    elapsed;

    // Register port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            grace_reg   <= GRACE_RESET;
            period_reg  <= PERIOD_RESET;
            count_reg   <= COUNT_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_TIMEOUT: timeout_reg <= pwdata[MS_BITS-1:0];
                REG_GRACE:   grace_reg   <= pwdata[MS_BITS-1:0];
                REG_PERIOD:  period_reg  <= pwdata[MS_BITS-1:0];
                REG_COUNT:   count_reg   <= pwdata[COUNT_BITS-1:0];
                default:     timeout_reg <= timeout_reg;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_TIMEOUT: prdata = 32'(timeout_reg);
            REG_GRACE:   prdata = 32'(grace_reg);
            REG_PERIOD:  prdata = 32'(period_reg);
            REG_COUNT:   prdata = 32'(count_reg);
            default:     prdata = '0;
        endcase
    end

    // Command decode and global counters.
    assign s_tready = !pend;
    assign s_acc    = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tdata[2:0]);
    assign ch       = s_tdata[5:3];
    assign mon      = (count_reg > COUNT_BITS'(MON_MAX)) ? COUNT_BITS'(MON_MAX) : count_reg;
    assign thr      = (act_reg < grace_reg) ? grace_reg : timeout_reg;
    assign div_inc  = div_reg + MS_BITS'(1);
    assign launch   = s_acc && (cmd == CMD_TICK) && running_reg && (div_inc >= period_reg);

    always_comb begin
        act_next     = act_reg;
        div_next     = div_reg;
        running_next = running_reg;
        if (s_acc) begin
            case (cmd)
                CMD_TICK: begin
                    if (act_reg != MS_MAX) begin
                        act_next = act_reg + MS_BITS'(1);
                    end
                    if (running_reg) begin
                        div_next = (div_inc >= period_reg) ? '0 : div_inc;
                    end
                end
                CMD_START: begin
                    act_next     = '0;
                    div_next     = '0;
                    running_next = 1'b1;
                end
                CMD_STOP: begin
                    running_next = 1'b0;
                end
                default: begin
                    running_next = running_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg     <= '0;
            div_reg     <= '0;
            running_reg <= 1'b0;
        end else begin
            act_reg     <= act_next;
            div_reg     <= div_next;
            running_reg <= running_next;
        end
    end

    // Check token control.
    assign pend     = |(hit_vec & seen_chain[CHANNELS:1]);
    assign tok_hit  = |(hit_vec & tok_vec);
    assign later    = |(hit_vec & seen_chain[CHANNELS-1:0]);
    assign out_free = !out_valid_reg || m_tready;
    assign step     = !tok_hit || out_free;
    assign emit     = pend && tok_hit && out_free;

    always_comb begin
        ctrl           = '0;
        ctrl.tick      = s_acc && (cmd == CMD_TICK);
        ctrl.restart   = s_acc && (cmd == CMD_START);
        ctrl.recover   = s_acc && (cmd == CMD_RECOVER) && running_reg;
        ctrl.heartbeat = s_acc && (cmd == CMD_HEARTBEAT) && running_reg;
        ctrl.channel   = ch;
        ctrl.mon       = mon;
        ctrl.pend      = pend;
        ctrl.step      = step;
        ctrl.emit      = emit;
    end

    assign tok_chain[0]  = launch;
    assign seen_chain[0] = 1'b0;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
        mchw_cell #(
            .AGE_BITS (AGE_BITS),
            .INDEX    (i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .thr      (thr),
            .tok_in   (tok_chain[i]),
            .seen_in  (seen_chain[i]),
            .tok_out  (tok_chain[i+1]),
            .seen_out (seen_chain[i+1]),
            .hit      (hit_vec[i]),
            .age_sel  (age_sel[i])
        );
    end

    assign tok_vec = tok_chain[CHANNELS:1];

    always_comb begin
        tok_age = '0;
        tok_idx = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            tok_age = tok_age | age_sel[i];
            if (tok_vec[i]) begin
                tok_idx = tok_idx | CH_BITS'(i);
            end
        end
    end

    assign tok_age_ext = CMP_W'(tok_age);
    assign elapsed     = (tok_age_ext > CMP_W'(MS_MAX)) ? MS_MAX : tok_age_ext[MS_BITS-1:0];

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_ch_reg   <= tok_idx;
            out_el_reg   <= elapsed;
            out_thr_reg  <= thr;
            out_last_reg <= !later;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_thr_reg, out_el_reg, out_ch_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_tok_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_vec))
        else $error("check token is held by more than one cell");

    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!out_valid_reg || m_tready))
        else $error("event overwrote an undelivered event");

    a_no_launch_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> !launch)
        else $error("check launched while stopped");

    a_hit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(hit_vec) <= int'(mon))
        else $error("unmonitored channel flagged for a check");

    a_emit_sets_stale: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> !tok_hit || !$stable(tok_vec))
        else $error("token stayed on a channel that was just reported");
`endif

endmodule

// ----- hdl/mchw_cell.sv -----
// One channel cell: age counter, stale flag and the check token stage.
module mchw_cell
    import mchw_pkg::*;
#(
    parameter int AGE_BITS = 16,
    parameter int INDEX    = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cell_ctrl_t          ctrl,
    input  logic [MS_BITS-1:0]  thr,
    input  logic                tok_in,
    input  logic                seen_in,
    output logic                tok_out,
    output logic                seen_out,
    output logic                hit,
    output logic [AGE_BITS-1:0] age_sel
);

    localparam int  CMP_W    = (AGE_BITS > MS_BITS) ? AGE_BITS : MS_BITS;
    localparam bit  IN_RANGE = INDEX < EVENT_LIMIT;
    localparam logic [COUNT_BITS-1:0] IDX = COUNT_BITS'(INDEX);
    localparam logic [AGE_BITS-1:0]   AGE_MAX = {AGE_BITS{1'b1}};

    logic [AGE_BITS-1:0] age_reg, age_next;
    logic                stale_reg, stale_next;
    logic                tok_reg, tok_next;
    logic                monitored;
    logic                hb_match;
    logic [CMP_W-1:0]    age_ext;
    logic [CMP_W-1:0]    thr_ext;

    assign monitored = IN_RANGE && (IDX < ctrl.mon);
    assign hb_match  = ctrl.heartbeat && monitored && (ctrl.channel == CH_BITS'(INDEX));
    assign age_ext   = CMP_W'(age_reg);
    assign thr_ext   = CMP_W'(thr);
    assign hit       = monitored && !stale_reg && (age_ext >= thr_ext);

    always_comb begin
        age_next = age_reg;
        if (ctrl.restart || hb_match) begin
            age_next = '0;
        end else if (ctrl.tick && age_reg != AGE_MAX) begin
            age_next = age_reg + AGE_BITS'(1);
        end
    end

    always_comb begin
        stale_next = stale_reg;
        if (ctrl.restart || ctrl.recover || hb_match) begin
            stale_next = 1'b0;
        end else if (ctrl.emit && tok_reg) begin
            stale_next = 1'b1;
        end
    end

    always_comb begin
        if (ctrl.pend) begin
            tok_next = ctrl.step ? tok_in : tok_reg;
        end else begin
            tok_next = (INDEX == 0) ? tok_in : 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_reg   <= '0;
            stale_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end else begin
            age_reg   <= age_next;
            stale_reg <= stale_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out  = tok_reg;
    assign seen_out = seen_in | tok_reg;
    assign age_sel  = tok_reg ? age_reg : '0;

endmodule

// ----- verif/multi_channel_heartbeat_watchdog_checker.sv -----
// Checker that predicts the watchdog's stale events and compares them with the m_ beats.
module multi_channel_heartbeat_watchdog_checker
    import mchw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                 NUM_CH  = 8;
    localparam logic [MS_BITS-1:0] MS_FULL = '1;

    typedef struct {
        logic [CH_BITS-1:0] chan;
        logic [MS_BITS-1:0] elapsed;
        logic [MS_BITS-1:0] thr;
        logic               last;
    } stale_event_t;

    stale_event_t stale_events_q[$];

    logic [MS_BITS-1:0]    age [NUM_CH];
    logic                  stale [NUM_CH];
    logic [MS_BITS-1:0]    act_age;
    logic [MS_BITS-1:0]    divider;
    logic                  running;
    logic [MS_BITS-1:0]    timeout_cfg;
    logic [MS_BITS-1:0]    grace_cfg;
    logic [MS_BITS-1:0]    period_cfg;
    logic [COUNT_BITS-1:0] count_cfg;
    int                    err_cnt;

    function automatic int watched_channels();
        int n;
        n = count_cfg;
        if (n > NUM_CH) n = NUM_CH;
        if (n > EVENT_LIMIT) n = EVENT_LIMIT;
        return n;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        err_cnt++;
    endtask

    task automatic timeout_check();
        logic [MS_BITS-1:0] thr;
        logic               hit [NUM_CH];
        int                 last_hit;
        stale_event_t       ev;
        thr = (act_age < grace_cfg) ? grace_cfg : timeout_cfg;
        last_hit = -1;
        for (int i = 0; i < NUM_CH; i++) begin
            hit[i] = (i < watched_channels()) && !stale[i] && (age[i] >= thr);
            if (hit[i]) last_hit = i;
        end
        for (int i = 0; i < NUM_CH; i++) begin
            if (hit[i]) begin
                stale[i] = 1'b1;
                ev.chan = CH_BITS'(i);
                ev.elapsed = age[i];
                ev.thr = thr;
                ev.last = (i == last_hit);
                stale_events_q.insert(stale_events_q.size(), ev);
            end
        end
    endtask

    task automatic apply_command(logic [2:0] cmd, logic [CH_BITS-1:0] ch);
        case (cmd)
            CMD_TICK: begin
                for (int i = 0; i < NUM_CH; i++) begin
                    if (age[i] != MS_FULL) age[i]++;
                end
                if (act_age != MS_FULL) act_age++;
                if (running) begin
                    divider = divider + 1'b1;
                    if (divider >= period_cfg) begin
                        divider = '0;
                        timeout_check();
                    end
                end
            end
            CMD_HEARTBEAT: begin
                if (running && ch < watched_channels()) begin
                    age[ch] = '0;
                    stale[ch] = 1'b0;
                end
            end
            CMD_RECOVER: begin
                if (running) begin
                    for (int i = 0; i < NUM_CH; i++) stale[i] = 1'b0;
                end
            end
            CMD_START: begin
                for (int i = 0; i < NUM_CH; i++) begin
                    age[i] = '0;
                    stale[i] = 1'b0;
                end
                act_age = '0;
                divider = '0;
                running = 1'b1;
            end
            CMD_STOP: begin
                running = 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin
        stale_event_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_CH; i++) begin
                age[i] = '0;
                stale[i] = 1'b0;
            end
            act_age = '0;
            divider = '0;
            running = 1'b0;
            timeout_cfg = TIMEOUT_RESET;
            grace_cfg = GRACE_RESET;
            period_cfg = PERIOD_RESET;
            count_cfg = COUNT_RESET;
            stale_events_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_TIMEOUT: timeout_cfg = pwdata[MS_BITS-1:0];
                    REG_GRACE:   grace_cfg = pwdata[MS_BITS-1:0];
                    REG_PERIOD:  period_cfg = pwdata[MS_BITS-1:0];
                    REG_COUNT:   count_cfg = pwdata[COUNT_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                apply_command(s_tdata[2:0], s_tdata[5:3]);
            end
            if (m_tvalid && m_tready) begin
                if (stale_events_q.size() == 0) begin
                    report("stale event beat with none expected, channel", m_tdata[2:0], -1);
                end else begin
                    want = stale_events_q.pop_front();
                    if (m_tdata[2:0] != want.chan)
                        report("stale_channel", m_tdata[2:0], want.chan);
                    if (m_tdata[18:3] != want.elapsed)
                        report("elapsed", m_tdata[18:3], want.elapsed);
                    if (m_tdata[34:19] != want.thr)
                        report("threshold_ms", m_tdata[34:19], want.thr);
                    if (m_tlast != want.last)
                        report("last", m_tlast, want.last);
                end
            end
        end
        errors <= err_cnt;
        pending <= stale_events_q.size();
    end

endmodule

// ----- verif/multi_channel_heartbeat_watchdog_tb.sv -----
// Top of the watchdog testbench: clock, reset, command and register stimulus, and the verdict.
module multi_channel_heartbeat_watchdog_tb
    import mchw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SETTLE_CYCLES  = 16;
    localparam int         LIMIT_NS       = 30_000_000;
    localparam int         PHASE_ITEMS    = 22;
    localparam int         WIDE_TICKS     = 4;
    localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;
    localparam logic [3:0] PHASE_COUNTS [6] = '{4'd8, 4'd15, 4'd0, 4'd5, 4'd8, 4'd2};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // command[2:0], channel[5:3], zero[7:6]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // stale_channel[2:0], elapsed[18:3], threshold_ms[34:19],
                             // zero[39:35]
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    bit          idle_on = 1'b1;

    multi_channel_heartbeat_watchdog u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    multi_channel_heartbeat_watchdog_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall = $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_cmd(logic [2:0] cmd, logic [CH_BITS-1:0] ch);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, ch, cmd};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(logic [15:0] tmo, logic [15:0] grace, logic [15:0] period,
                             logic [3:0] count);
        settle();
        write_reg(REG_TIMEOUT, {16'd0, tmo});
        write_reg(REG_GRACE, {16'd0, grace});
        write_reg(REG_PERIOD, {16'd0, period});
        write_reg(REG_COUNT, {28'd0, count});
    endtask

    task automatic random_command();
        int                 pick;
        logic [CH_BITS-1:0] ch;
        pick = $urandom_range(0, 99);
        ch = CH_BITS'($urandom_range(0, 7));
        if (pick < 48) send_cmd(CMD_TICK, ch);
        else if (pick < 78) send_cmd(CMD_HEARTBEAT, ch);
        else if (pick < 85) send_cmd(CMD_RECOVER, ch);
        else if (pick < 90) send_cmd(CMD_STOP, ch);
        else if (pick < 96) send_cmd(CMD_START, ch);
        else send_cmd(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), ch);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Commands while stopped, and the unused codes.
        send_cmd(CMD_HEARTBEAT, 3'd0);
        send_cmd(CMD_RECOVER, 3'd0);
        send_cmd(CMD_STOP, 3'd0);
        for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) send_cmd(3'(c), 3'd7);
        send_cmd(CMD_TICK, 3'd7);

        // Zero period and timeout: each non-stale channel goes stale at every running tick.
        configure(16'd0, 16'd0, 16'd0, 4'd8);
        send_cmd(CMD_START, 3'd0);
        send_cmd(CMD_TICK, 3'd0);
        send_cmd(CMD_HEARTBEAT, 3'd7);
        send_cmd(CMD_TICK, 3'd0);
        send_cmd(CMD_RECOVER, 3'd0);
        send_cmd(CMD_TICK, 3'd0);
        send_cmd(CMD_STOP, 3'd0);
        send_cmd(CMD_TICK, 3'd0);
        send_cmd(CMD_START, 3'd0);
        send_cmd(CMD_START, 3'd0);

        // The grace window hands over to the normal timeout.
        configure(16'd1, 16'd3, 16'd1, 4'd2);
        send_cmd(CMD_START, 3'd0);
        send_cmd(CMD_HEARTBEAT, 3'd5);
        repeat (3) send_cmd(CMD_TICK, 3'd0);
        send_cmd(CMD_HEARTBEAT, 3'd1);
        send_cmd(CMD_TICK, 3'd0);

        for (int k = 0; k < 6; k++) begin
            if (k == 5) idle_on = 1'b0;
            configure(16'($urandom_range(0, 12)), 16'($urandom_range(0, 6)),
                      16'($urandom_range(0, 3)), PHASE_COUNTS[k]);
            send_cmd(CMD_START, CH_BITS'($urandom_range(0, 7)));
            repeat (PHASE_ITEMS) random_command();
        end

        // The widest register settings.
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
        send_cmd(CMD_START, 3'd0);
        repeat (WIDE_TICKS) send_cmd(CMD_TICK, CH_BITS'($urandom_range(0, 7)));
        settle();
        write_reg(REG_PERIOD, 32'd1);
        send_cmd(CMD_RECOVER, 3'd0);
        send_cmd(CMD_TICK, 3'd0);

        settle();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
